// File: rtl/tlvsp_pkg.sv
package tlvsp_pkg;

    // Position of the current byte within an object
    typedef enum logic [1:0] {
        PH_TYPE   = 2'd0,
        PH_LEN_LO = 2'd1,
        PH_LEN_HI = 2'd2,
        PH_VALUE  = 2'd3
    } phase_t;

    // Error codes reported per item
    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_TOO_MANY  = 2'd1;
    localparam logic [1:0] ERR_TRUNCATED = 2'd2;

    localparam int CountWidth  = 7;
    localparam int LengthWidth = 15;

    // One result item
    typedef struct packed {
        phase_t                  byte_role;
        logic [5:0]              object_index;
        logic [7:0]              type_code;
        logic [LengthWidth-1:0]  value_length;
        logic [7:0]              data_byte;
        logic                    object_done;
        logic [1:0]              error_code;
    } result_t;

endpackage

// File: rtl/tlvsp_core.sv
module tlvsp_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step,
    input  logic [7:0]                    in_byte,
    input  logic                          last_byte,
    input  logic [tlvsp_pkg::CountWidth-1:0] max_objects,
    output tlvsp_pkg::result_t            result
);
    import tlvsp_pkg::*;

    phase_t                  phase_reg, phase_next;
    logic [7:0]              type_reg, type_next;
    logic [7:0]              len_lo_reg, len_lo_next;
    logic [LengthWidth-1:0]  length_reg, length_next;
    logic [LengthWidth-1:0]  left_reg, left_next;
    logic [CountWidth-1:0]   count_reg, count_next;
    logic                    err_reg, err_next;

    logic                    too_many;
    logic [LengthWidth-1:0]  hi_length;
    logic [LengthWidth-1:0]  left_dec;

    // Shared decode of the current byte and parse state
    assign too_many  = (count_reg >= max_objects);
    assign hi_length = in_byte[7] ? '0 : {in_byte[6:0], len_lo_reg};
    assign left_dec  = left_reg - LengthWidth'(1);

    // Next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (!err_reg)
        begin
            case (phase_reg)
                PH_TYPE:   if (!too_many) phase_next = PH_LEN_LO;
                PH_LEN_LO: phase_next = PH_LEN_HI;
                PH_LEN_HI: phase_next = (hi_length == '0) ? PH_TYPE : PH_VALUE;
                PH_VALUE:  if (left_dec == '0) phase_next = PH_TYPE;
                default:   phase_next = PH_TYPE;
            endcase
        end
        if (last_byte)
            phase_next = PH_TYPE;
    end

    // Result and data state
    always_comb
    begin
        type_next   = type_reg;
        len_lo_next = len_lo_reg;
        length_next = length_reg;
        left_next   = left_reg;
        count_next  = count_reg;
        err_next    = err_reg;

        result.byte_role    = PH_TYPE;
        result.object_index = count_reg[5:0];
        result.type_code    = '0;
        result.value_length = '0;
        result.data_byte    = in_byte;
        result.object_done  = 1'b0;
        result.error_code   = ERR_NONE;

        if (!err_reg)
        begin
            case (phase_reg)
                PH_TYPE:
                begin
                    result.type_code = in_byte;
                    if (too_many)
                    begin
                        result.error_code = ERR_TOO_MANY;
                        err_next = 1'b1;
                    end
                    else
                    begin
                        type_next   = in_byte;
                        length_next = '0;
                        if (last_byte)
                            result.error_code = ERR_TRUNCATED;
                    end
                end
                PH_LEN_LO:
                begin
                    result.byte_role = PH_LEN_LO;
                    result.type_code = type_reg;
                    len_lo_next      = in_byte;
                    if (last_byte)
                        result.error_code = ERR_TRUNCATED;
                end
                PH_LEN_HI:
                begin
                    result.byte_role    = PH_LEN_HI;
                    result.type_code    = type_reg;
                    result.value_length = hi_length;
                    length_next         = hi_length;
                    if (hi_length == '0)
                    begin
                        result.object_done = 1'b1;
                        count_next = count_reg + CountWidth'(1);
                    end
                    else
                    begin
                        left_next = hi_length;
                        if (last_byte)
                            result.error_code = ERR_TRUNCATED;
                    end
                end
                PH_VALUE:
                begin
                    result.byte_role    = PH_VALUE;
                    result.type_code    = type_reg;
                    result.value_length = length_reg;
                    left_next           = left_dec;
                    if (left_dec == '0)
                    begin
                        result.object_done = 1'b1;
                        count_next = count_reg + CountWidth'(1);
                    end
                    else if (last_byte)
                        result.error_code = ERR_TRUNCATED;
                end
                default:
                begin
                    result.byte_role = PH_TYPE;
                end
            endcase
        end

        // End of buffer starts a fresh parse
        if (last_byte)
        begin
            type_next   = '0;
            len_lo_next = '0;
            length_next = '0;
            left_next   = '0;
            count_next  = '0;
            err_next    = 1'b0;
        end
    end

    // Parse state, advanced once per accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_TYPE;
            type_reg   <= '0;
            len_lo_reg <= '0;
            length_reg <= '0;
            left_reg   <= '0;
            count_reg  <= '0;
            err_reg    <= 1'b0;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            type_reg   <= type_next;
            len_lo_reg <= len_lo_next;
            length_reg <= length_next;
            left_reg   <= left_next;
            count_reg  <= count_next;
            err_reg    <= err_next;
        end
    end

endmodule

// File: rtl/tlv_stream_parser.sv
// TLV stream parser: splits a byte stream into type / length / value objects.
// Input channel (in_valid, in_ready): one buffer byte per item, with
// last_byte marking the end of the buffer. Output channel (out_valid,
// out_ready): one result item per input item, giving the byte's role, the
// object index, type, value length, the byte itself, completion and error.
// Latency: a result appears in the output register the cycle after its
// item is accepted. Throughput: one item per cycle unless the output stalls;
// the parse state is a handful of registers updated by short logic, so the
// next byte can be taken in the following cycle.
// Stall: in_ready stays high while the output register is empty or is
// being taken in the same cycle; when the receiver holds out_ready low
// with a result pending, input stalls until that result is taken.
// Reset: the parse returns to expecting a type byte with an empty chain,
// the output register is empty and max_objects returns to 50. max_objects is
// written through cfg_wr_en / cfg_wr_data while idle; user rule, unenforced.
// After an item with last_byte the parse state restarts for a new buffer.
module tlv_stream_parser (
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        cfg_wr_en,
    input  logic [6:0]  cfg_wr_data,
    // input channel
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  in_byte,
    input  logic        last_byte,
    // output channel
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  byte_role,
    output logic [5:0]  object_index,
    output logic [7:0]  type_code,
    output logic [14:0] value_length,
    output logic [7:0]  data_byte,
    output logic        object_done,
    output logic [1:0]  error_code
);
    import tlvsp_pkg::*;

    logic [CountWidth-1:0] max_obj_reg;
    logic                  valid_reg, valid_next;
    result_t               res_reg;
    result_t               res_comb;
    logic                  accept;

    // Handshake
    assign in_ready   = !valid_reg || out_ready;
    assign accept     = in_valid && in_ready;
    assign valid_next = accept || (valid_reg && !out_ready);

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_obj_reg <= CountWidth'(50);
        else if (cfg_wr_en)
            max_obj_reg <= cfg_wr_data;
    end

    tlvsp_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (accept),
        .in_byte     (in_byte),
        .last_byte   (last_byte),
        .max_objects (max_obj_reg),
        .result      (res_comb)
    );

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            res_reg <= res_comb;
    end

    assign out_valid    = valid_reg;
    assign byte_role    = res_reg.byte_role;
    assign object_index = res_reg.object_index;
    assign type_code    = res_reg.type_code;
    assign value_length = res_reg.value_length;
    assign data_byte    = res_reg.data_byte;
    assign object_done  = res_reg.object_done;
    assign error_code   = res_reg.error_code;

endmodule
